// File: sv/lucc_pkg.sv
// Shared types, constant tables and helper functions for the Lucifer CBC encryptor.
package lucc_pkg;

  localparam int unsigned BlkW   = 64;
  localparam int unsigned Rounds = 16;
  localparam int unsigned RndW   = $clog2(Rounds);

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_IV_LOW   = 2'd2,
    REG_IV_HIGH  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Round key: control byte and eight mask bytes (byte j in bits 8j+7:8j).
  typedef struct packed {
    logic [7:0]      ctl;
    logic [BlkW-1:0] mask;
  } rkey_t;

  localparam logic [7:0] BOX0 [256] = '{
    8'h57,8'h15,8'h75,8'h36,8'h17,8'h37,8'h14,8'h54,8'h74,8'h76,8'h16,8'h35,8'h55,8'h77,8'h34,8'h56,
    8'hdf,8'h9d,8'hfd,8'hbe,8'h9f,8'hbf,8'h9c,8'hdc,8'hfc,8'hfe,8'h9e,8'hbd,8'hdd,8'hff,8'hbc,8'hde,
    8'hcf,8'h8d,8'hed,8'hae,8'h8f,8'haf,8'h8c,8'hcc,8'hec,8'hee,8'h8e,8'had,8'hcd,8'hef,8'hac,8'hce,
    8'hd3,8'h91,8'hf1,8'hb2,8'h93,8'hb3,8'h90,8'hd0,8'hf0,8'hf2,8'h92,8'hb1,8'hd1,8'hf3,8'hb0,8'hd2,
    8'hd7,8'h95,8'hf5,8'hb6,8'h97,8'hb7,8'h94,8'hd4,8'hf4,8'hf6,8'h96,8'hb5,8'hd5,8'hf7,8'hb4,8'hd6,
    8'h5f,8'h1d,8'h7d,8'h3e,8'h1f,8'h3f,8'h1c,8'h5c,8'h7c,8'h7e,8'h1e,8'h3d,8'h5d,8'h7f,8'h3c,8'h5e,
    8'hdb,8'h99,8'hf9,8'hba,8'h9b,8'hbb,8'h98,8'hd8,8'hf8,8'hfa,8'h9a,8'hb9,8'hd9,8'hfb,8'hb8,8'hda,
    8'h43,8'h01,8'h61,8'h22,8'h03,8'h23,8'h00,8'h40,8'h60,8'h62,8'h02,8'h21,8'h41,8'h63,8'h20,8'h42,
    8'hc3,8'h81,8'he1,8'ha2,8'h83,8'ha3,8'h80,8'hc0,8'he0,8'he2,8'h82,8'ha1,8'hc1,8'he3,8'ha0,8'hc2,
    8'hc7,8'h85,8'he5,8'ha6,8'h87,8'ha7,8'h84,8'hc4,8'he4,8'he6,8'h86,8'ha5,8'hc5,8'he7,8'ha4,8'hc6,
    8'hcb,8'h89,8'he9,8'haa,8'h8b,8'hab,8'h88,8'hc8,8'he8,8'hea,8'h8a,8'ha9,8'hc9,8'heb,8'ha8,8'hca,
    8'h4b,8'h09,8'h69,8'h2a,8'h0b,8'h2b,8'h08,8'h48,8'h68,8'h6a,8'h0a,8'h29,8'h49,8'h6b,8'h28,8'h4a,
    8'h5b,8'h19,8'h79,8'h3a,8'h1b,8'h3b,8'h18,8'h58,8'h78,8'h7a,8'h1a,8'h39,8'h59,8'h7b,8'h38,8'h5a,
    8'h47,8'h05,8'h65,8'h26,8'h07,8'h27,8'h04,8'h44,8'h64,8'h66,8'h06,8'h25,8'h45,8'h67,8'h24,8'h46,
    8'h4f,8'h0d,8'h6d,8'h2e,8'h0f,8'h2f,8'h0c,8'h4c,8'h6c,8'h6e,8'h0e,8'h2d,8'h4d,8'h6f,8'h2c,8'h4e,
    8'h53,8'h11,8'h71,8'h32,8'h13,8'h33,8'h10,8'h50,8'h70,8'h72,8'h12,8'h31,8'h51,8'h73,8'h30,8'h52
  };

  localparam logic [7:0] DIFF [64] = '{
    8'h04,8'h10,8'h20,8'h02,8'h01,8'h08,8'h40,8'h80,
    8'h80,8'h04,8'h10,8'h20,8'h02,8'h01,8'h08,8'h40,
    8'h40,8'h80,8'h04,8'h10,8'h20,8'h02,8'h01,8'h08,
    8'h08,8'h40,8'h80,8'h04,8'h10,8'h20,8'h02,8'h01,
    8'h01,8'h08,8'h40,8'h80,8'h04,8'h10,8'h20,8'h02,
    8'h02,8'h01,8'h08,8'h40,8'h80,8'h04,8'h10,8'h20,
    8'h20,8'h02,8'h01,8'h08,8'h40,8'h80,8'h04,8'h10,
    8'h10,8'h20,8'h02,8'h01,8'h08,8'h40,8'h80,8'h04
  };

  function automatic logic [7:0] box0(input logic [7:0] x);
    return BOX0[x];
  endfunction

  // Second box is the first one read with the index nibbles swapped.
  function automatic logic [7:0] box1(input logic [7:0] x);
    return BOX0[{x[3:0], x[7:4]}];
  endfunction

  // Key byte bit permutation.
  function automatic logic [7:0] perm_byte(input logic [7:0] b);
    return {b[5], b[2], b[3], b[7], b[4], b[6], b[0], b[1]};
  endfunction

endpackage

// File: sv/lucc_keysched.sv
// Round key selection: control byte and permuted mask bytes for even or odd rounds.
module lucc_keysched (
  input  logic [lucc_pkg::BlkW-1:0] key_low,
  input  logic [lucc_pkg::BlkW-1:0] key_high,
  input  logic                      odd,
  output lucc_pkg::rkey_t           rkey
);
  import lucc_pkg::*;

  logic [7:0] pb [16];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pb[i]     = perm_byte(key_low[8*i +: 8]);
      pb[i + 8] = perm_byte(key_high[8*i +: 8]);
    end
  end

  // Schedule index advances by eight per round, so keys repeat every two rounds.
  always_comb begin
    if (odd) begin
      rkey.ctl = key_low[7:0];
      for (int j = 0; j < 8; j++) rkey.mask[8*j +: 8] = pb[1 + j];
    end else begin
      rkey.ctl = key_high[7:0];
      for (int j = 0; j < 8; j++) rkey.mask[8*j +: 8] = pb[(9 + j) % 16];
    end
  end

endmodule

// File: sv/lucc_round.sv
// One cipher round: S-box selection, masking, diffusion into the left half, half swap.
module lucc_round (
  input  logic [lucc_pkg::BlkW-1:0] left,
  input  logic [lucc_pkg::BlkW-1:0] right,
  input  lucc_pkg::rkey_t           rkey,
  output logic [lucc_pkg::BlkW-1:0] left_next,
  output logic [lucc_pkg::BlkW-1:0] right_next
);
  import lucc_pkg::*;

  logic [7:0]      t;
  logic [7:0]      s [8];
  logic [BlkW-1:0] f;

  always_comb begin
    t = rkey.ctl;
    for (int j = 0; j < 8; j++) t = t ^ right[8*j +: 8];
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      s[j] = (t[7-j] ? box1(right[8*j +: 8]) : box0(right[8*j +: 8])) ^ rkey.mask[8*j +: 8];
    end
  end

  always_comb begin
    f = '0;
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 8; k++) f[8*k +: 8] = f[8*k +: 8] ^ (s[j] & DIFF[8*j + k]);
    end
  end

  assign left_next  = right;
  assign right_next = left ^ f;

endmodule

// File: sv/lucifer_cbc_encrypt.sv
// Lucifer-style 128-bit block cipher, CBC encryption, one round per clock while the last round is not held.
//
// Each input transaction carries one 128-bit plaintext block, which is XORed
// with the chain value (the IV when s_tuser is set, else the previous
// ciphertext) and encrypted under the 128-bit key in 16 rounds. The
// single round unit is reused once per cycle, and the next block cannot
// start before the previous ciphertext exists. s_tready is high only while
// no block is in the rounds; a finished result sits in an output register,
// so a new block is taken while the old result still waits. If that
// register is still full when a block reaches its last round, the last
// round holds until the output side drains. Key and IV registers are
// written through the cfg port (always ready) and must only change while
// the block is idle; a new key applies from the next block, a new IV at
// the next block that starts a message. Without any message start after
// reset, the chain value is zero.
module lucifer_cbc_encrypt (
  input  logic                       clk,
  input  logic                       rst,
  // slave side
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [2*lucc_pkg::BlkW-1:0] s_tdata,  // block_low[63:0], block_high[127:64]
  input  logic                       s_tuser,   // first_block
  // master side
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [2*lucc_pkg::BlkW-1:0] m_tdata,  // cipher_low[63:0], cipher_high[127:64]
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [lucc_pkg::BlkW-1:0]  cfg_data
);
  import lucc_pkg::*;

  state_t          state, state_next;
  logic [RndW-1:0] rnd;
  logic [BlkW-1:0] left, right;
  logic [BlkW-1:0] left_rnd, right_rnd;
  logic [BlkW-1:0] key_low, key_high, iv_low, iv_high;
  logic [BlkW-1:0] chain_low, chain_high;
  logic            out_valid;
  logic [2*BlkW-1:0] out_data;

  logic            start;     // input transaction accepted
  logic            last_rnd;  // current round is the final one
  logic            advance;   // round result is taken this cycle
  logic            finish;    // block completes, result goes to the output register
  rkey_t           rkey;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      iv_low   <= '0;
      iv_high  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_IV_LOW:   iv_low   <= cfg_data;
        REG_IV_HIGH:  iv_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- shared round hardware
  lucc_keysched u_keysched (
    .key_low  (key_low),
    .key_high (key_high),
    .odd      (rnd[0]),
    .rkey     (rkey)
  );

  lucc_round u_round (
    .left       (left),
    .right      (right),
    .rkey       (rkey),
    .left_next  (left_rnd),
    .right_next (right_rnd)
  );

  // ---- sequencer: next state
  assign last_rnd = (rnd == RndW'(Rounds - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_RUN;
      ST_RUN:  if (finish)   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    advance  = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_RUN:  advance  = !last_rnd || !out_valid || m_tready;
      default: ;
    endcase
  end

  assign start  = s_tvalid && s_tready;
  assign finish = advance && last_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= '0;
      end else if (advance) begin
        rnd <= rnd + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- datapath: half registers, chain value, result register
  always_ff @(posedge clk) begin
    if (start) begin
      left  <= s_tdata[BlkW-1:0]      ^ (s_tuser ? iv_low  : chain_low);
      right <= s_tdata[2*BlkW-1:BlkW] ^ (s_tuser ? iv_high : chain_high);
    end else if (advance) begin
      left  <= left_rnd;
      right <= right_rnd;
    end
  end

  // Final half swap: the last round's outputs go out undone.
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= {left_rnd, right_rnd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_low  <= '0;
      chain_high <= '0;
    end else if (finish) begin
      chain_low  <= right_rnd;
      chain_high <= left_rnd;
    end
  end

endmodule
